FILE: rtl/tsx_pkg.sv
// shared types, constants and state helpers for the tls server-name extractor
package tsx_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65536;
    localparam int unsigned OFF_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned LEN_W = 16;
    localparam int unsigned ACC_W = 24;
    localparam int unsigned REG_W = ACC_W + 1;
    localparam int unsigned CMP_W = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 2;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned PTR_W = $clog2(QDEPTH);
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] REC_HANDSHAKE = 8'd22;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
    localparam int unsigned OFF_HS_TYPE = 5;
    localparam int unsigned OFF_LEN_FIRST = 6;
    localparam int unsigned OFF_LEN_LAST = 8;
    localparam int unsigned OFF_SID_LEN = 43;
    localparam int unsigned HS_HDR_BYTES = 9;

    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_REC,
        PH_FIXED,
        PH_SID,
        PH_CSLEN,
        PH_CS,
        PH_COMPLEN,
        PH_COMP,
        PH_EXTSLEN,
        PH_EXTHDR,
        PH_EXTSKIP,
        PH_SNIHDR,
        PH_NAME,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND,
        ST_NOT_HS,
        ST_NOT_CH,
        ST_NO_SNI,
        ST_TRUNC
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   skip_remaining;
        logic [OFF_W-1:0]   region_end;
        logic [ACC_W-1:0]   acc;
        logic [LEN_W-1:0]   ext_len;
        logic [LEN_W-1:0]   name_remaining;
        status_t            outcome;
    } parse_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic       last;
        status_t    status;
    } out_item_t;

    typedef struct packed {
        logic       name_valid;
        logic       status_valid;
        out_item_t  name_item;
        out_item_t  status_item;
    } push_t;

    function automatic parse_state_t reset_state();
        parse_state_t s;
        s.phase = PH_REC;
        s.byte_offset = '0;
        s.skip_remaining = '0;
        s.region_end = '0;
        s.acc = '0;
        s.ext_len = '0;
        s.name_remaining = '0;
        s.outcome = ST_NO_SNI;
        return s;
    endfunction

    function automatic parse_state_t start_field(parse_state_t s_in, phase_t ph);
        parse_state_t s;
        s = s_in;
        s.phase = ph;
        s.skip_remaining = '0;
        s.acc = '0;
        s.ext_len = '0;
        return s;
    endfunction

    function automatic parse_state_t start_skip(parse_state_t s_in, logic [LEN_W-1:0] count,
                                                phase_t skip_ph, phase_t next_ph);
        parse_state_t s;
        s = s_in;
        if (count == '0) begin
            s = start_field(s, next_ph);
        end else begin
            s.phase = skip_ph;
            s.skip_remaining = count;
        end
        return s;
    endfunction

    function automatic parse_state_t skip_one(parse_state_t s_in, phase_t next_ph);
        parse_state_t s;
        s = s_in;
        if (s.skip_remaining != '0) begin
            s.skip_remaining = s.skip_remaining - LEN_W'(1);
        end
        if (s.skip_remaining == '0) begin
            s = start_field(s, next_ph);
        end
        return s;
    endfunction

endpackage

FILE: rtl/tsx_parser.sv
// client hello walker: per-byte state update and result generation
module tsx_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      data_byte,
    input  logic            end_of_packet,
    output tsx_pkg::push_t  push
);

    tsx_pkg::parse_state_t state_reg, state_next;
    logic [tsx_pkg::REG_W-1:0] region_sum;
    logic [tsx_pkg::CMP_W-1:0] off_w;
    logic emit_name;

    always_comb begin
        state_next = state_reg;
        emit_name = 1'b0;
        region_sum = '0;
        off_w = tsx_pkg::CMP_W'(state_reg.byte_offset);
        unique case (state_reg.phase)
            tsx_pkg::PH_REC: begin
                if (data_byte != tsx_pkg::REC_HANDSHAKE) begin
                    state_next.outcome = tsx_pkg::ST_NOT_HS;
                    state_next.phase = tsx_pkg::PH_DONE;
                end else begin
                    state_next.phase = tsx_pkg::PH_FIXED;
                end
            end
            tsx_pkg::PH_FIXED: begin
                if (state_reg.byte_offset == tsx_pkg::OFF_W'(tsx_pkg::OFF_HS_TYPE)) begin
                    if (data_byte != tsx_pkg::HS_CLIENT_HELLO) begin
                        state_next.outcome = tsx_pkg::ST_NOT_CH;
                        state_next.phase = tsx_pkg::PH_DONE;
                    end
                end else if (state_reg.byte_offset >= tsx_pkg::OFF_W'(tsx_pkg::OFF_LEN_FIRST)
                        && state_reg.byte_offset <= tsx_pkg::OFF_W'(tsx_pkg::OFF_LEN_LAST)) begin
                    state_next.acc = {state_reg.acc[15:0], data_byte};
                    if (state_reg.byte_offset == tsx_pkg::OFF_W'(tsx_pkg::OFF_LEN_LAST)) begin
                        region_sum = tsx_pkg::REG_W'(state_next.acc)
                                   + tsx_pkg::REG_W'(tsx_pkg::HS_HDR_BYTES);
                        if (region_sum > tsx_pkg::REG_W'(tsx_pkg::MAX_PACKET_BYTES)) begin
                            state_next.region_end = tsx_pkg::OFF_W'(tsx_pkg::MAX_PACKET_BYTES);
                        end else begin
                            state_next.region_end = tsx_pkg::OFF_W'(region_sum);
                        end
                    end
                end else if (state_reg.byte_offset == tsx_pkg::OFF_W'(tsx_pkg::OFF_SID_LEN)) begin
                    state_next = tsx_pkg::start_skip(state_reg, tsx_pkg::LEN_W'(data_byte),
                                                     tsx_pkg::PH_SID, tsx_pkg::PH_CSLEN);
                end
            end
            tsx_pkg::PH_SID: begin
                state_next = tsx_pkg::skip_one(state_reg, tsx_pkg::PH_CSLEN);
            end
            tsx_pkg::PH_CSLEN: begin
                state_next.acc = {8'h00, state_reg.acc[7:0], data_byte};
                state_next.skip_remaining = state_reg.skip_remaining + tsx_pkg::LEN_W'(1);
                if (state_next.skip_remaining == tsx_pkg::LEN_W'(2)) begin
                    state_next = tsx_pkg::start_skip(state_next, state_next.acc[15:0],
                                                     tsx_pkg::PH_CS, tsx_pkg::PH_COMPLEN);
                end
            end
            tsx_pkg::PH_CS: begin
                state_next = tsx_pkg::skip_one(state_reg, tsx_pkg::PH_COMPLEN);
            end
            tsx_pkg::PH_COMPLEN: begin
                state_next = tsx_pkg::start_skip(state_reg, tsx_pkg::LEN_W'(data_byte),
                                                 tsx_pkg::PH_COMP, tsx_pkg::PH_EXTSLEN);
            end
            tsx_pkg::PH_COMP: begin
                state_next = tsx_pkg::skip_one(state_reg, tsx_pkg::PH_EXTSLEN);
            end
            tsx_pkg::PH_EXTSLEN: begin
                state_next.skip_remaining = state_reg.skip_remaining + tsx_pkg::LEN_W'(1);
                if (state_next.skip_remaining == tsx_pkg::LEN_W'(2)) begin
                    state_next = tsx_pkg::start_field(state_next, tsx_pkg::PH_EXTHDR);
                end
            end
            tsx_pkg::PH_EXTHDR: begin
                if (state_reg.skip_remaining == '0
                        && !(off_w + tsx_pkg::CMP_W'(3)
                             < tsx_pkg::CMP_W'(state_reg.region_end))) begin
                    state_next.phase = tsx_pkg::PH_DONE;
                end else begin
                    if (state_reg.skip_remaining < tsx_pkg::LEN_W'(2)) begin
                        state_next.acc = {8'h00, state_reg.acc[7:0], data_byte};
                    end else begin
                        state_next.ext_len = {state_reg.ext_len[7:0], data_byte};
                    end
                    state_next.skip_remaining = state_reg.skip_remaining + tsx_pkg::LEN_W'(1);
                    if (state_next.skip_remaining == tsx_pkg::LEN_W'(4)) begin
                        if (state_next.acc == '0
                                && off_w + tsx_pkg::CMP_W'(1)
                                   + tsx_pkg::CMP_W'(state_next.ext_len)
                                   <= tsx_pkg::CMP_W'(state_reg.region_end)) begin
                            state_next = tsx_pkg::start_field(state_next, tsx_pkg::PH_SNIHDR);
                        end else begin
                            state_next = tsx_pkg::start_skip(state_next, state_next.ext_len,
                                                             tsx_pkg::PH_EXTSKIP,
                                                             tsx_pkg::PH_EXTHDR);
                        end
                    end
                end
            end
            tsx_pkg::PH_EXTSKIP: begin
                state_next = tsx_pkg::skip_one(state_reg, tsx_pkg::PH_EXTHDR);
            end
            tsx_pkg::PH_SNIHDR: begin
                state_next.skip_remaining = state_reg.skip_remaining + tsx_pkg::LEN_W'(1);
                if (state_next.skip_remaining >= tsx_pkg::LEN_W'(4)) begin
                    state_next.acc = {8'h00, state_reg.acc[7:0], data_byte};
                end
                if (state_next.skip_remaining == tsx_pkg::LEN_W'(5)) begin
                    state_next.name_remaining = state_next.acc[15:0];
                    if (state_next.name_remaining == '0) begin
                        state_next.phase = tsx_pkg::PH_DONE;
                    end else begin
                        state_next.outcome = tsx_pkg::ST_TRUNC;
                        state_next.phase = tsx_pkg::PH_NAME;
                    end
                end
            end
            tsx_pkg::PH_NAME: begin
                emit_name = 1'b1;
                if (state_reg.name_remaining != '0) begin
                    state_next.name_remaining = state_reg.name_remaining - tsx_pkg::LEN_W'(1);
                end
                if (state_next.name_remaining == '0) begin
                    state_next.outcome = tsx_pkg::ST_FOUND;
                    state_next.phase = tsx_pkg::PH_DONE;
                end
            end
            default: begin
                state_next.phase = tsx_pkg::PH_DONE;
            end
        endcase

        if (state_reg.byte_offset < tsx_pkg::OFF_W'(tsx_pkg::MAX_PACKET_BYTES)) begin
            state_next.byte_offset = state_reg.byte_offset + tsx_pkg::OFF_W'(1);
        end

        push.name_valid = in_accept && emit_name;
        push.name_item.kind = tsx_pkg::KIND_NAME;
        push.name_item.name_byte = data_byte;
        push.name_item.last = !end_of_packet;
        push.name_item.status = tsx_pkg::ST_FOUND;

        push.status_valid = in_accept && end_of_packet;
        push.status_item.kind = tsx_pkg::KIND_STATUS;
        push.status_item.name_byte = 8'h00;
        push.status_item.last = 1'b1;
        push.status_item.status = state_next.outcome;

        if (end_of_packet) begin
            state_next = tsx_pkg::reset_state();
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsx_pkg::reset_state();
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // packet end always restarts at the record type byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.status_valid |=> state_reg.phase == tsx_pkg::PH_REC && state_reg.byte_offset == '0)
        else $error("parser not restarted after packet end");

    // offset saturates at the packet limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.byte_offset <= tsx_pkg::OFF_W'(tsx_pkg::MAX_PACKET_BYTES))
        else $error("byte offset beyond packet limit");

    // a name byte is only produced while a name length is outstanding
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.name_valid |-> state_reg.name_remaining != '0)
        else $error("name byte with no name length left");

endmodule

FILE: rtl/tsx_out_queue.sv
// result queue taking up to two items per cycle and draining one per cycle while out_ready is high
module tsx_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsx_pkg::push_t      push,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output tsx_pkg::out_item_t  out_item
);

    tsx_pkg::out_item_t mem_reg [tsx_pkg::QDEPTH];
    logic [tsx_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tsx_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tsx_pkg::CNT_W-1:0] count_reg, count_next;
    logic [tsx_pkg::PTR_W-1:0] status_idx;
    logic [tsx_pkg::CNT_W-1:0] push_cnt;
    logic pop;

    always_comb begin
        out_valid = count_reg != '0;
        out_item = mem_reg[rd_ptr_reg];
        space_ok = count_reg <= tsx_pkg::CNT_W'(tsx_pkg::QDEPTH - 2);
        pop = out_valid && out_ready;
        push_cnt = tsx_pkg::CNT_W'(push.name_valid) + tsx_pkg::CNT_W'(push.status_valid);
        status_idx = wr_ptr_reg + tsx_pkg::PTR_W'(push.name_valid);
        wr_ptr_next = wr_ptr_reg + tsx_pkg::PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + tsx_pkg::PTR_W'(pop);
        count_next = count_reg + push_cnt - tsx_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.name_valid) begin
            mem_reg[wr_ptr_reg] <= push.name_item;
        end
        if (push.status_valid) begin
            mem_reg[status_idx] <= push.status_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tsx_pkg::CNT_W'(tsx_pkg::QDEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != '0 |-> space_ok)
        else $error("push into queue without room for two items");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> count_reg == $past(count_reg) + $past(push_cnt))
        else $error("queue count lost track of pushed items");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[tsx_pkg::PTR_W-1:0] == tsx_pkg::PTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers and count disagree");

endmodule

FILE: rtl/tls_sni_extractor.sv
// top level of the tls client hello server-name extractor
// Takes one TCP payload byte per cycle and accepts a byte in every cycle while the four-entry
// result queue has room for two items. Each accepted byte is parsed in the same cycle and its
// results are registered into the queue for draining. Name bytes come out as kind 0 items;
// the final byte of a packet adds a kind 1 status item, so that byte can yield two results,
// drained at one per cycle while m_tready is high. Sustained rate is one byte per cycle when m_tready stays high.
module tls_sni_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tlast,   // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // name_byte [7:0], status [10:8], zero [15:11]
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // kind
);

    tsx_pkg::push_t push;
    tsx_pkg::out_item_t out_item;
    logic in_accept;

    assign in_accept = s_tvalid && s_tready;

    tsx_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .data_byte     (s_tdata),
        .end_of_packet (s_tlast),
        .push          (push)
    );

    tsx_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {5'b00000, out_item.status, out_item.name_byte};
    assign m_tlast = out_item.last;
    assign m_tuser = out_item.kind;

endmodule
